// ===== rtl/nps_pkg.sv =====
// nps_pkg: shared constants and the command type of the path converter
`timescale 1ns / 1ps

package nps_pkg;

  localparam int ROOM_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int BYTE_W     = 8;
  localparam int OUT_ROOM_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATH_SEP     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 1'd1;

  localparam logic [BYTE_W-1:0]     PATH_SEP_RESET     = 8'd47;
  localparam logic [CFG_DATA_W-1:0] OUT_CAPACITY_RESET = 16'd4096;

  localparam logic [BYTE_W-1:0] DOT_BYTE = 8'h2E;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

  // emission slots of one command, sent lowest slot first
  localparam int SLOT_N    = 5;
  localparam int SLOT_SEP  = 0;
  localparam int SLOT_DOT1 = 1;
  localparam int SLOT_DOT2 = 2;
  localparam int SLOT_BYTE = 3;
  localparam int SLOT_NUL  = 4;

  typedef struct packed {
    logic [SLOT_N-1:0]     slots;
    logic                  err;
    logic [BYTE_W-1:0]     sep;
    logic [BYTE_W-1:0]     data;
    logic [OUT_ROOM_W-1:0] room;
  } nps_cmd_t;

endpackage

// ===== rtl/nps_if.sv =====
// nps_if: handshake channels of the path converter
`timescale 1ns / 1ps

interface nps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface nps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic [15:0] out_room_left;
  modport source (output valid, output out_byte, output out_last, output out_error,
                  output out_room_left, input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_error,
                  input out_room_left, output ready);
endinterface

interface nps_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/nps_front.sv =====
// nps_front: name parser, room check and command generation
`timescale 1ns / 1ps

module nps_front import nps_pkg::*; #(
  parameter int ROOM_BITS = ROOM_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  in_last,
  input  logic [BYTE_W-1:0]     path_sep,
  input  logic [CFG_DATA_W-1:0] out_capacity,
  output logic                  push,
  output nps_cmd_t              cmd
);

  logic                 at_name_start;
  logic                 comp_started;
  logic [1:0]           held_dots;
  logic                 dropping;
  logic [ROOM_BITS-1:0] room_left;

  logic [ROOM_BITS-1:0] room;
  logic [SLOT_N-1:0]    slots;
  logic [1:0]           held_dots_next;
  logic                 comp_started_next;
  logic                 name_err;
  logic                 err;
  logic [2:0]           n;

  always_comb begin
    room              = at_name_start ? ROOM_BITS'(out_capacity) : room_left;
    slots             = '0;
    held_dots_next    = held_dots;
    comp_started_next = comp_started;
    name_err          = 1'b0;
    if (in_byte == NUL_BYTE) begin
      name_err          = at_name_start | in_last | (held_dots != 2'd0);
      comp_started_next = 1'b0;
    end else begin
      comp_started_next = 1'b1;
      if (!comp_started) begin
        if (in_byte == DOT_BYTE) begin
          held_dots_next = 2'd1;
        end else begin
          slots[SLOT_SEP]  = 1'b1;
          slots[SLOT_BYTE] = 1'b1;
        end
      end else if (held_dots != 2'd0) begin
        if (in_byte == DOT_BYTE && held_dots < 2'd2) begin
          held_dots_next = held_dots + 2'd1;
        end else begin
          // component proved safe: release separator and held dots
          slots[SLOT_SEP]  = 1'b1;
          slots[SLOT_DOT1] = 1'b1;
          slots[SLOT_DOT2] = (held_dots == 2'd2);
          slots[SLOT_BYTE] = 1'b1;
          held_dots_next   = 2'd0;
        end
      end else begin
        slots[SLOT_BYTE] = 1'b1;
      end
      if (in_last) begin
        if (held_dots_next != 2'd0) begin
          name_err = 1'b1;
        end else begin
          slots[SLOT_NUL] = 1'b1;
        end
      end
    end
    n = 3'(slots[0]) + 3'(slots[1]) + 3'(slots[2]) + 3'(slots[3]) + 3'(slots[4]);
    err = name_err | (ROOM_BITS'(n) > room);

    cmd.sep  = path_sep;
    cmd.data = in_byte;
    cmd.err  = err;
    if (err) begin
      cmd.slots = SLOT_N'(1) << SLOT_NUL;
      cmd.room  = OUT_ROOM_W'(room);
    end else begin
      cmd.slots = slots;
      cmd.room  = OUT_ROOM_W'(room - ROOM_BITS'(1));
    end
    push = accept && !dropping && (err || (slots != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_name_start <= 1'b1;
      comp_started  <= 1'b0;
      held_dots     <= 2'd0;
      dropping      <= 1'b0;
    end else if (accept) begin
      if (dropping || in_last) begin
        if (in_last) begin
          at_name_start <= 1'b1;
          comp_started  <= 1'b0;
          held_dots     <= 2'd0;
          dropping      <= 1'b0;
        end
      end else begin
        at_name_start <= 1'b0;
        comp_started  <= comp_started_next;
        held_dots     <= held_dots_next;
        dropping      <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !dropping && !err) begin
      room_left <= room - ROOM_BITS'(n);
    end
  end

endmodule

// ===== rtl/nps_queue.sv =====
// nps_queue: small command queue between parser and emitter
`timescale 1ns / 1ps

module nps_queue import nps_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  nps_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output nps_cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nps_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/nps_back.sv =====
// nps_back: expands commands into output bytes, one per cycle while dout.ready
`timescale 1ns / 1ps

module nps_back import nps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  nps_cmd_t         q_head,
  output logic             q_pop,
  nps_out_if.source        dout
);

  logic [SLOT_N-1:0]     pending;
  logic                  err;
  logic [BYTE_W-1:0]     sep;
  logic [BYTE_W-1:0]     data;
  logic [OUT_ROOM_W-1:0] room;

  logic [SLOT_N-1:0] lowest;
  logic [SLOT_N-1:0] pending_next;
  logic              xfer;
  logic              load;

  always_comb begin
    dout.valid   = (pending != '0);
    lowest       = pending & (~pending + SLOT_N'(1));
    pending_next = pending & ~lowest;
    xfer         = dout.valid && dout.ready;
    load         = (pending == '0) || (xfer && pending_next == '0);
    q_pop        = load && q_valid;

    dout.out_last      = lowest[SLOT_NUL];
    dout.out_error     = err;
    dout.out_room_left = room;
    if (lowest[SLOT_SEP]) begin
      dout.out_byte = sep;
    end else if (lowest[SLOT_DOT1] || lowest[SLOT_DOT2]) begin
      dout.out_byte = DOT_BYTE;
    end else if (lowest[SLOT_BYTE]) begin
      dout.out_byte = data;
    end else begin
      dout.out_byte = NUL_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= q_valid ? q_head.slots : '0;
    end else if (xfer) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err  <= q_head.err;
      sep  <= q_head.sep;
      data <= q_head.data;
      room <= q_head.room;
    end else if (xfer) begin
      room <= room - OUT_ROOM_W'(1);
    end
  end

endmodule

// ===== rtl/nul_path_to_separator_path_unit.sv =====
// nul_path_to_separator_path_unit: top level of the nul-delimited name to path converter
`timescale 1ns / 1ps

// converts a name whose components are split by nul bytes into a separator path: every
// component goes out behind the path_sep byte and a good name closes with a nul byte.
// runs of nuls collapse; a leading or trailing nul, a component of exactly one or two
// dots, or output that would overrun out_capacity (separators and closing nul counted)
// ends the packet with one error item (byte 0, last and error set, room as before the
// failing input byte) and the rest of that name is dropped without results.
// timing: the input side takes one byte per cycle; each input byte turns into zero to
// five result items; the emitter sends one per cycle while the output is ready, so a byte
// that releases a separator and held dots keeps the emitter busy with up to five items.
// the command queue of QUEUE_DEPTH entries between parser and emitter absorbs that;
// input ready drops only while the queue is full. when the emitter is free, the first result
// of an input transfer passes a queue entry and then the emitter's pending register.
// path_sep applies from the next input byte, out_capacity from the next name.

module nul_path_to_separator_path_unit import nps_pkg::*; #(
  parameter int ROOM_BITS   = ROOM_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  nps_cfg_if.sink    cfg,
  nps_in_if.sink     din,
  nps_out_if.source  dout
);

  // configuration registers
  logic [BYTE_W-1:0]     path_sep;
  logic [CFG_DATA_W-1:0] out_capacity;

  // front to queue
  logic     accept;
  logic     push;
  nps_cmd_t push_cmd;

  // queue to back
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  nps_cmd_t q_head;

  // register writes always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_sep     <= PATH_SEP_RESET;
      out_capacity <= OUT_CAPACITY_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATH_SEP:     path_sep     <= cfg.data[BYTE_W-1:0];
        REG_OUT_CAPACITY: out_capacity <= cfg.data;
      endcase
    end
  end

  // input transfer whenever the queue has a free entry
  assign din.ready = !q_full;
  assign accept    = din.valid && din.ready;

  nps_front #(
    .ROOM_BITS (ROOM_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (din.in_byte),
    .in_last      (din.in_last),
    .path_sep     (path_sep),
    .out_capacity (out_capacity),
    .push         (push),
    .cmd          (push_cmd)
  );

  nps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  nps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .dout    (dout)
  );

endmodule
